FILE: src/partition_gap_fit_allocator_core_assert.svh
// Assertion macros shared by the checkers of the gap fit allocator.
// Each use expands into one labeled concurrent assertion that is held off
// while reset is high and reports through $error.
`ifndef PARTITION_GAP_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define PARTITION_GAP_FIT_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGFA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PGFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed one cycle later");

`endif

FILE: src/pgfa_pkg.sv
// ----------------------------------------------------------------------------
// pgfa_pkg
// Types, constants and codes shared by the partition gap fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pgfa_pkg;

  // Table geometry.
  localparam int SLOTS  = 4;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed field widths.
  localparam int ADDR_W    = 31;
  localparam int CURSOR_W  = ADDR_W + 1;
  localparam int GAP_NUM_W = 3;
  localparam int KEY_W     = ADDR_W + SLOT_W;

  // Operation codes carried in the input tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  // Fit modes.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DISK_SIZE    = 2'd0;
  localparam logic [1:0] REG_FIT_MODE     = 2'd1;
  localparam logic [1:0] REG_FIRST_USABLE = 2'd2;

  // Reset value of the first usable byte.
  localparam logic [ADDR_W-1:0] FIRST_USABLE_RESET = 31'd128;

  typedef struct packed {
    logic [ADDR_W-1:0] disk_size;
    logic [1:0]        fit_mode;
    logic [ADDR_W-1:0] first_usable;
  } cfg_t;

  typedef struct packed {
    logic              used;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
  } slot_t;

  typedef struct packed {
    logic                 status;
    logic [ADDR_W-1:0]    gap_start;
    logic [ADDR_W-1:0]    gap_size;
    logic [GAP_NUM_W-1:0] gap_number;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

`default_nettype wire

FILE: src/pgfa_table.sv
// ----------------------------------------------------------------------------
// pgfa_table
// Partition slot table: one write port for load items, one read port for
// the scan of the placement engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pgfa_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [1:0]                wr_slot,
  input  wire pgfa_pkg::slot_t           wr_data,
  input  wire logic [pgfa_pkg::SLOT_W-1:0] rd_idx,
  output pgfa_pkg::slot_t                rd_data
);

  logic [pgfa_pkg::SLOTS-1:0]        used;
  logic [pgfa_pkg::ADDR_W-1:0]       start  [pgfa_pkg::SLOTS];
  logic [pgfa_pkg::ADDR_W-1:0]       length [pgfa_pkg::SLOTS];
  logic                              in_range;
  logic [pgfa_pkg::SLOT_W-1:0]       wr_idx;

  // Slot numbers past the table are dropped.
  assign in_range = (32'(wr_slot) < pgfa_pkg::SLOTS);
  assign wr_idx   = pgfa_pkg::SLOT_W'(wr_slot);

  // Used flags are cleared by reset; start and length only matter when used.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_en && in_range) begin
      used[wr_idx] <= wr_data.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      start[wr_idx]  <= wr_data.start;
      length[wr_idx] <= wr_data.length;
    end
  end

  assign rd_data.used   = used[rd_idx];
  assign rd_data.start  = start[rd_idx];
  assign rd_data.length = length[rd_idx];

endmodule

`default_nettype wire

FILE: src/pgfa_engine.sv
// ----------------------------------------------------------------------------
// pgfa_engine
// Placement sequencer: picks partitions in start order one slot per cycle,
// forms each free gap and runs it through the fit selection.
// ----------------------------------------------------------------------------
`default_nettype none

module pgfa_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start_req,
  input  wire logic [pgfa_pkg::ADDR_W-1:0]   req_size,
  input  wire pgfa_pkg::cfg_t                cfg,
  output logic [pgfa_pkg::SLOT_W-1:0]        rd_idx,
  input  wire pgfa_pkg::slot_t               rd_slot,
  input  wire logic                          res_take,
  output pgfa_pkg::eng_stat_t                stat,
  output pgfa_pkg::result_t                  res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_FIT   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [pgfa_pkg::SLOT_W-1:0] LAST_IDX = pgfa_pkg::SLOT_W'(pgfa_pkg::SLOTS - 1);

  logic [2:0]                          state;
  logic [pgfa_pkg::SLOT_W-1:0]         idx;
  logic [pgfa_pkg::ADDR_W-1:0]         req;
  logic [pgfa_pkg::CURSOR_W-1:0]       cursor;
  logic                                have_prev;
  logic [pgfa_pkg::KEY_W-1:0]          prev_key;
  logic                                best_found;
  logic [pgfa_pkg::KEY_W-1:0]          best_key;
  logic [pgfa_pkg::ADDR_W-1:0]         best_len;
  logic                                gap_ok;
  logic                                last_gap;
  logic [pgfa_pkg::ADDR_W-1:0]         gap_start;
  logic [pgfa_pkg::ADDR_W-1:0]         gap_size;
  logic [pgfa_pkg::GAP_NUM_W-1:0]      gap_cnt;
  logic                                found;
  logic [pgfa_pkg::ADDR_W-1:0]         pick_start;
  logic [pgfa_pkg::ADDR_W-1:0]         pick_size;
  logic [pgfa_pkg::GAP_NUM_W-1:0]      pick_num;

  logic [pgfa_pkg::KEY_W-1:0]          cand_key;
  logic                                cand_hit;
  logic [pgfa_pkg::ADDR_W-1:0]         best_start;
  logic                                gap_fits;
  logic                                take_gap;

  // Scan compare: the next partition is the smallest (start, slot) key above
  // the one placed last, so equal starts go in slot order.
  assign cand_key   = {rd_slot.start, idx};
  assign cand_hit   = rd_slot.used
                    && (!have_prev || (cand_key > prev_key))
                    && (!best_found || (cand_key < best_key));
  assign best_start = best_key[pgfa_pkg::KEY_W-1:pgfa_pkg::SLOT_W];
  assign rd_idx     = idx;

  // Fit selection for the gap held in the gap registers.
  assign gap_fits = gap_ok && (gap_size >= req);
  always_comb begin
    take_gap = 1'b0;
    if (gap_fits) begin
      if (!found) begin
        take_gap = 1'b1;
      end else if (cfg.fit_mode == pgfa_pkg::FIT_BEST) begin
        take_gap = (gap_size < pick_size);
      end else if (cfg.fit_mode == pgfa_pkg::FIT_WORST) begin
        take_gap = (gap_size > pick_size);
      end
    end
  end

  // Sequencer and its datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      have_prev  <= 1'b0;
      best_found <= 1'b0;
      found      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start_req) begin
            state      <= S_SCAN;
            idx        <= '0;
            req        <= req_size;
            cursor     <= {1'b0, cfg.first_usable};
            have_prev  <= 1'b0;
            best_found <= 1'b0;
            found      <= 1'b0;
            gap_cnt    <= '0;
          end
        end
        S_SCAN: begin
          if (cand_hit) begin
            best_found <= 1'b1;
            best_key   <= cand_key;
            best_len   <= rd_slot.length;
          end
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (best_found) begin
            gap_ok    <= ({1'b0, best_start} > cursor);
            gap_start <= cursor[pgfa_pkg::ADDR_W-1:0];
            gap_size  <= best_start - cursor[pgfa_pkg::ADDR_W-1:0];
            cursor    <= {1'b0, best_start} + {1'b0, best_len};
            prev_key  <= best_key;
            have_prev <= 1'b1;
            last_gap  <= 1'b0;
            state     <= S_FIT;
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          // Closing gap from the cursor up to the disk end.
          gap_ok    <= ({1'b0, cfg.disk_size} > cursor);
          gap_start <= cursor[pgfa_pkg::ADDR_W-1:0];
          gap_size  <= cfg.disk_size - cursor[pgfa_pkg::ADDR_W-1:0];
          last_gap  <= 1'b1;
          state     <= S_FIT;
        end
        S_FIT: begin
          if (take_gap) begin
            found      <= 1'b1;
            pick_start <= gap_start;
            pick_size  <= gap_size;
            pick_num   <= gap_cnt;
          end
          if (gap_ok) begin
            gap_cnt <= gap_cnt + 1'b1;
          end
          if (last_gap) begin
            state <= S_DONE;
          end else begin
            state      <= S_SCAN;
            idx        <= '0;
            best_found <= 1'b0;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  // With no fitting gap every field but the status reads zero.
  assign res.status     = !found;
  assign res.gap_start  = found ? pick_start : '0;
  assign res.gap_size   = found ? pick_size : '0;
  assign res.gap_number = found ? pick_num : '0;

endmodule

`default_nettype wire

FILE: src/partition_gap_fit_allocator_core.sv
// Partition gap fit allocator. Load transfers (tuser 0) write one slot of a
// four-slot partition table and give no result. Place transfers (tuser 1)
// walk the used partitions in start order from the first usable byte,
// collect the free gaps and return the one chosen by first, best or worst
// fit, or a no-space status. The scan reads one table slot per cycle and
// compares its key with the last placed key and the best key so far, once
// for each partition it places. The input side is not ready while a place
// request is worked on and until its result moves into the output register.
// Results sit in an output register, so the next item is accepted while a
// result still waits. Configuration writes are taken in every cycle and are
// meant for times when the block is idle.
// ----------------------------------------------------------------------------
// partition_gap_fit_allocator_core
// Top level: stream ports, configuration registers, slot table, placement
// engine and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_gap_fit_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata, from bit 0: slot[1:0], used[2], part_start[33:3],
  // part_length[64:34], request_size[95:65]
  input  wire logic [95:0] s_tdata,
  // s_tuser: operation[0]
  input  wire logic        s_tuser,
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata, from bit 0: gap_start[30:0], gap_size[61:31],
  // gap_number[64:62], zero fill[71:65]
  output logic [71:0]      m_tdata,
  // m_tuser: status[0]
  output logic             m_tuser
);

  pgfa_pkg::cfg_t                   cfg;
  pgfa_pkg::slot_t                  wr_data;
  pgfa_pkg::slot_t                  rd_slot;
  pgfa_pkg::eng_stat_t              stat;
  pgfa_pkg::result_t                res;
  pgfa_pkg::result_t                out_res;
  logic [pgfa_pkg::SLOT_W-1:0]      rd_idx;
  logic                             in_xfer;
  logic                             load_en;
  logic                             place_en;
  logic                             out_free;

  // Input transfers.
  assign s_tready = stat.idle;
  assign in_xfer  = s_tvalid && s_tready;
  assign load_en  = in_xfer && (s_tuser == pgfa_pkg::OP_LOAD);
  assign place_en = in_xfer && (s_tuser == pgfa_pkg::OP_PLACE);

  assign wr_data.used   = s_tdata[2];
  assign wr_data.start  = s_tdata[33:3];
  assign wr_data.length = s_tdata[64:34];

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disk_size    <= '0;
      cfg.fit_mode     <= pgfa_pkg::FIT_FIRST;
      cfg.first_usable <= pgfa_pkg::FIRST_USABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pgfa_pkg::REG_DISK_SIZE:    cfg.disk_size    <= cfg_data;
        pgfa_pkg::REG_FIT_MODE:     cfg.fit_mode     <= cfg_data[1:0];
        pgfa_pkg::REG_FIRST_USABLE: cfg.first_usable <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pgfa_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load_en),
    .wr_slot (s_tdata[1:0]),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_slot)
  );

  pgfa_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start_req (place_en),
    .req_size  (s_tdata[95:65]),
    .cfg       (cfg),
    .rd_idx    (rd_idx),
    .rd_slot   (rd_slot),
    .res_take  (out_free),
    .stat      (stat),
    .res       (res)
  );

  // Result register: loads when empty or when its transfer completes.
  assign out_free = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stat.done) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.gap_number, out_res.gap_size, out_res.gap_start};
  assign m_tuser = out_res.status;

endmodule

`default_nettype wire

FILE: src/pgfa_checker.sv
// ----------------------------------------------------------------------------
// pgfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "partition_gap_fit_allocator_core_assert.svh"

module pgfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic        m_tuser
);

  logic place_xfer;

  assign place_xfer = s_tvalid && s_tready && (s_tuser == pgfa_pkg::OP_PLACE);

  // A held result stays offered until its transfer.
  `PGFA_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // A place request keeps the input side busy while the gaps are worked out.
  `PGFA_ASSERT_NEXT(a_busy, clk, rst, place_xfer, !s_tready)

  // A no-space result carries no gap.
  `PGFA_ASSERT_SAME(a_nospace, clk, rst, m_tvalid && m_tuser, m_tdata == 72'd0)

  // A found gap is never empty.
  `PGFA_ASSERT_SAME(a_nonempty, clk, rst, m_tvalid && !m_tuser, m_tdata[61:31] != 31'd0)

endmodule

bind partition_gap_fit_allocator_core pgfa_checker u_pgfa_checker (.*);

`default_nettype wire
